FILE: rtl/annexb_pkg.sv
// Package for the Annex B NAL unit splitter: result record, verdict and
// parse phase codes, the verdict helper and the saturating position helper. No dependencies.
package annexb_pkg;

  localparam int unsigned PosW = 21;
  localparam logic [PosW-1:0] MaxBufferBytes = 21'd1048576;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [4:0] TypeInvalid = 5'd0;
  localparam logic [4:0] TypeAud     = 5'd9;

  typedef enum logic [1:0] {
    VerdictSend    = 2'd0,
    VerdictSkip    = 2'd1,
    VerdictInvalid = 2'd2,
    VerdictNoUnit  = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    PhaseSeek = 2'd0,
    PhaseType = 2'd1,
    PhaseUnit = 2'd2,
    PhaseDrop = 2'd3
  } phase_e;

  typedef struct packed {
    verdict_e         verdict;
    logic [4:0]       unit_type;
    logic [PosW-1:0]  unit_offset;
    logic [PosW-1:0]  unit_length;
    logic             runs_to_end;
    logic             end_of_run;
  } result_t;

  function automatic verdict_e verdict_of(logic [4:0] unit_type);
    if (unit_type == TypeInvalid) return VerdictInvalid;
    if (unit_type == TypeAud) return VerdictSkip;
    return VerdictSend;
  endfunction

  function automatic logic [PosW-1:0] sat_inc(logic [PosW-1:0] v);
    return (v >= MaxBufferBytes) ? MaxBufferBytes : v + 1'b1;
  endfunction

endpackage

FILE: rtl/annexb_nal_unit_splitter_top.sv
// Annex B NAL unit splitter: scans one byte per cycle unless stalled, closes
// units on start codes or buffer end. Depends on annexb_pkg.
//
// Results are registered in the result queue before they reach the output.
// Throughput: one byte per cycle; a byte that closes a unit and ends the buffer
// yields two results, drained one per cycle while out_stall_i is low from a
// 4-entry result queue; the input stalls while fewer than two entries are free.
// Reset (async, active low) clears the parse state and empties the queue.
module annexb_nal_unit_splitter_top
  import annexb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                buffer_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          verdict_o,
  output logic [4:0]          unit_type_o,
  output logic [PosW-1:0]     unit_offset_o,
  output logic [PosW-1:0]     unit_length_o,
  output logic                runs_to_end_o,
  output logic                end_of_run_o
);

  // parse state
  logic [31:0]     win_q, win_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] off_q, off_d;
  logic [4:0]      type_q, type_d;
  phase_e          phase_q, phase_d;

  // result queue
  result_t              fifo_q [FifoDepth];
  logic [FifoAw-1:0]    rd_ptr_q, wr_ptr_q;
  logic [FifoCntW-1:0]  cnt_q;

  logic            accept, pop;
  logic [31:0]     win_sh;
  logic            sc, sc4;
  logic [PosW-1:0] rel, drop, close_len;
  logic [PosW:0]   end_len_w;
  logic            close_v, end_v;
  result_t         close_r, end_r, slot0, slot1;
  logic [1:0]      n_push;

  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = cnt_q > FifoCntW'(FifoDepth - 2);

  assign win_sh = {win_q[23:0], data_byte_i};
  assign sc     = win_sh[23:0] == 24'h000001;
  assign sc4    = win_sh == 32'h0000_0001;

  // closing length drops the start code that ends the unit
  assign rel       = pos_q - off_q;
  assign drop      = sc4 ? PosW'(3) : PosW'(2);
  assign close_len = (rel >= drop) ? rel - drop : '0;

  always_comb begin
    win_d   = win_sh;
    pos_d   = sat_inc(pos_q);
    off_d   = off_q;
    type_d  = type_q;
    phase_d = phase_q;
    close_v = 1'b0;
    close_r = '{verdict: verdict_of(type_q), unit_type: type_q, unit_offset: off_q,
                unit_length: close_len, runs_to_end: 1'b0, end_of_run: 1'b0};
    end_v   = 1'b0;
    end_r   = '{verdict: VerdictNoUnit, unit_type: '0, unit_offset: '0,
                unit_length: '0, runs_to_end: 1'b0, end_of_run: 1'b1};
    end_len_w = '0;

    unique case (phase_q)
      PhaseSeek: begin
        if (sc) begin
          off_d   = sat_inc(pos_q);
          phase_d = PhaseType;
          win_d   = '1;
        end
      end
      PhaseType: begin
        type_d  = data_byte_i[4:0];
        phase_d = PhaseUnit;
      end
      PhaseUnit: begin
        if (sc) begin
          close_v = 1'b1;
          if (type_q == TypeInvalid) begin
            phase_d = PhaseDrop;
          end else begin
            off_d   = sat_inc(pos_q);
            phase_d = PhaseType;
            win_d   = '1;
          end
        end
      end
      PhaseDrop: ;
      default: ;
    endcase

    if (buffer_end_i) begin
      end_len_w = {1'b0, pos_q} - {1'b0, off_d} + 1'b1;
      unique case (phase_d)
        PhaseSeek: begin
          end_v = 1'b1;
        end
        PhaseType: begin
          // start code on the last byte: empty trailing unit
          end_v = 1'b1;
          end_r.verdict     = VerdictInvalid;
          end_r.unit_offset = off_d;
          end_r.runs_to_end = 1'b1;
        end
        PhaseUnit: begin
          end_v = 1'b1;
          end_r.verdict     = verdict_of(type_d);
          end_r.unit_type   = type_d;
          end_r.unit_offset = off_d;
          end_r.unit_length = (end_len_w > {1'b0, MaxBufferBytes}) ? MaxBufferBytes
                                                                  : end_len_w[PosW-1:0];
          end_r.runs_to_end = 1'b1;
        end
        PhaseDrop: ;
        default: ;
      endcase
      win_d   = '1;
      pos_d   = '0;
      off_d   = '0;
      type_d  = '0;
      phase_d = PhaseSeek;
    end
  end

  always_comb begin
    slot0 = close_v ? close_r : end_r;
    slot0.end_of_run = !(close_v && end_v);
    slot1  = end_r;
    n_push = accept ? ({1'b0, close_v} + {1'b0, end_v}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '1;
      pos_q   <= '0;
      off_q   <= '0;
      type_q  <= '0;
      phase_q <= PhaseSeek;
    end else if (accept) begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      off_q   <= off_d;
      type_q  <= type_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_q + FifoAw'(pop);
      wr_ptr_q <= wr_ptr_q + FifoAw'(n_push);
      cnt_q    <= cnt_q + FifoCntW'(n_push) - FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= slot1;
    end
  end

  assign out_valid_o   = cnt_q != '0;
  assign verdict_o     = fifo_q[rd_ptr_q].verdict;
  assign unit_type_o   = fifo_q[rd_ptr_q].unit_type;
  assign unit_offset_o = fifo_q[rd_ptr_q].unit_offset;
  assign unit_length_o = fifo_q[rd_ptr_q].unit_length;
  assign runs_to_end_o = fifo_q[rd_ptr_q].runs_to_end;
  assign end_of_run_o  = fifo_q[rd_ptr_q].end_of_run;

endmodule

FILE: rtl/annexb_checker.sv
// Port-level checks for the Annex B NAL unit splitter, bound to the top level.
// Depends on annexb_pkg and annexb_nal_unit_splitter_top.
module annexb_checker
  import annexb_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [1:0]      verdict_o,
  input logic [4:0]      unit_type_o,
  input logic [PosW-1:0] unit_offset_o,
  input logic [PosW-1:0] unit_length_o,
  input logic            runs_to_end_o,
  input logic            end_of_run_o
);

  // a waiting request stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({verdict_o, unit_type_o, unit_offset_o, unit_length_o,
               runs_to_end_o, end_of_run_o}))
    else $error("output request dropped or changed while stalled");

  // with nothing queued the input must be open
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty result queue");

  // the buffer-end result is always the last one for its byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && runs_to_end_o |-> end_of_run_o)
    else $error("buffer-end result not marked as last");

  a_no_unit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VerdictNoUnit) |->
      (unit_type_o == '0) && (unit_offset_o == '0) && (unit_length_o == '0) &&
      !runs_to_end_o && end_of_run_o)
    else $error("no-unit result carries unit fields");

  // a stalled input request means results are backed up
  a_stall_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o)
    else $error("request stalled while the result queue is empty");

endmodule

bind annexb_nal_unit_splitter_top annexb_checker u_annexb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .verdict_o     (verdict_o),
  .unit_type_o   (unit_type_o),
  .unit_offset_o (unit_offset_o),
  .unit_length_o (unit_length_o),
  .runs_to_end_o (runs_to_end_o),
  .end_of_run_o  (end_of_run_o)
);

FILE: tb/annexb_nal_unit_splitter_top_test.sv
// Testbench for annexb_nal_unit_splitter_top: sends Annex B byte buffers and checks
// every unit descriptor against a scanner kept inside the bench. Depends on annexb_pkg
// and the splitter RTL.
module annexb_nal_unit_splitter_top_test;
  import annexb_pkg::*;

  localparam int RandomBytes = 1650;
  localparam int CycleLimit  = 4000000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      data_byte_i;
  logic            buffer_end_i;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [1:0]      verdict_o;
  logic [4:0]      unit_type_o;
  logic [PosW-1:0] unit_offset_o;
  logic [PosW-1:0] unit_length_o;
  logic            runs_to_end_o;
  logic            end_of_run_o;

  annexb_nal_unit_splitter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .buffer_end_i  (buffer_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .verdict_o     (verdict_o),
    .unit_type_o   (unit_type_o),
    .unit_offset_o (unit_offset_o),
    .unit_length_o (unit_length_o),
    .runs_to_end_o (runs_to_end_o),
    .end_of_run_o  (end_of_run_o)
  );

  // scanner state
  logic [31:0] scan_window;
  int unsigned scan_pos;
  int unsigned unit_off;
  logic [4:0]  unit_kind;
  phase_e      scan_phase;

  result_t    want_units[$];
  logic [7:0] frame_bytes[$];

  int errors = 0;
  int buffers = 0;
  int bytes_in = 0;
  int checked = 0;
  int cycles = 0;
  int stall_left = 0;
  bit idle_en = 1'b1;
  bit stall_en = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [PosW-1:0] clamp_pos(int unsigned v);
    return (v > MaxBufferBytes) ? MaxBufferBytes : v[PosW-1:0];
  endfunction

  function automatic verdict_e kind_verdict(logic [4:0] kind);
    case (kind)
      TypeInvalid: return VerdictInvalid;
      TypeAud:     return VerdictSkip;
      default:     return VerdictSend;
    endcase
  endfunction

  function automatic result_t make_unit(verdict_e v, logic [4:0] kind, int unsigned off,
                                        int unsigned len, logic to_end);
    result_t r;
    r.verdict     = v;
    r.unit_type   = kind;
    r.unit_offset = off[PosW-1:0];
    r.unit_length = len[PosW-1:0];
    r.runs_to_end = to_end;
    r.end_of_run  = 1'b0;
    return r;
  endfunction

  function automatic void reset_scan();
    scan_window = '1;
    scan_pos    = 0;
    unit_off    = 0;
    unit_kind   = '0;
    scan_phase  = PhaseSeek;
  endfunction

  // Advances the scanner by one byte and queues the descriptors it closes.
  function automatic void scan_byte(logic [7:0] b, logic last);
    int unsigned pos;
    int unsigned rel;
    int unsigned drop;
    logic        start;
    result_t     fresh[$];
    result_t     r;
    pos = scan_pos;
    scan_window = {scan_window[23:0], b};
    start = (scan_window[23:0] == 24'h000001);
    case (scan_phase)
      PhaseSeek: if (start) begin
        unit_off = clamp_pos(pos + 1);
        scan_phase = PhaseType;
        scan_window = '1;
      end
      PhaseType: begin
        unit_kind = b[4:0];
        scan_phase = PhaseUnit;
      end
      PhaseUnit: if (start) begin
        rel = pos - unit_off;
        // a 4-byte start code takes one more byte off the closing unit
        drop = (scan_window == 32'h1) ? 3 : 2;
        fresh.push_back(make_unit(kind_verdict(unit_kind), unit_kind, unit_off,
                                  clamp_pos((rel >= drop) ? rel - drop : 0), 1'b0));
        if (unit_kind == TypeInvalid) begin
          scan_phase = PhaseDrop;
        end else begin
          unit_off = clamp_pos(pos + 1);
          scan_phase = PhaseType;
          scan_window = '1;
        end
      end
      default: ;
    endcase
    if (last) begin
      case (scan_phase)
        PhaseSeek: fresh.push_back(make_unit(VerdictNoUnit, '0, 0, 0, 1'b0));
        PhaseType: fresh.push_back(make_unit(VerdictInvalid, '0, unit_off, 0, 1'b1));
        PhaseUnit: fresh.push_back(make_unit(kind_verdict(unit_kind), unit_kind, unit_off,
                                             clamp_pos(pos - unit_off + 1), 1'b1));
        default: ;
      endcase
      reset_scan();
    end else begin
      scan_pos = clamp_pos(pos + 1);
    end
    if (fresh.size() > 0) begin
      r = fresh.pop_back();
      r.end_of_run = 1'b1;
      fresh.push_back(r);
    end
    foreach (fresh[i]) want_units.push_back(fresh[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] nb;
    nb = 8'($urandom);
    case ($urandom_range(3))
      0, 1: nb = 8'h00;
      2:    nb = 8'h01;
      default: ;
    endcase
    return nb;
  endfunction

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  // One byte request; valid only drops when a gap is taken.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    buffer_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scan_byte(b, last);
    bytes_in++;
    if (last) buffers++;
  endtask

  task automatic send_buffer();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic test_directed();
    idle_en = 1'b1;
    stall_en = 1'b1;
    // no start code anywhere
    frame_bytes = {8'hFF};
    send_buffer();
    // 4-byte then 3-byte start code; the delimiter runs to the end
    frame_bytes = {8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h01,
                   {3'b100, TypeAud}, 8'hFF};
    send_buffer();
    // start code on the last byte closes a unit and leaves an empty trailing one
    frame_bytes = {8'h00, 8'h00, 8'h01, 8'hE1, 8'h00, 8'h00, 8'h01};
    send_buffer();
    // type zero: everything after its closing start code is dropped
    frame_bytes = {8'h00, 8'h00, 8'h01, {3'b100, TypeInvalid}, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_buffer();
  endtask

  task automatic test_random_buffers();
    int         shape;
    int         units;
    int         plen;
    int         r;
    logic [7:0] tb;
    logic [7:0] pb;
    while (bytes_in < RandomBytes) begin
      idle_en  = ($urandom_range(7) != 0);
      stall_en = ($urandom_range(7) != 0);
      shape = $urandom_range(99);
      frame_bytes.delete();
      if (shape < 10) begin
        plen = $urandom_range(1, 12);
        repeat (plen) frame_bytes.push_back(noise_byte());
      end else begin
        if ($urandom_range(7) == 0) frame_bytes.push_back(noise_byte());
        units = $urandom_range(1, 4);
        repeat (units) begin
          if ($urandom_range(1)) frame_bytes.push_back(8'h00);
          frame_bytes.push_back(8'h00);
          frame_bytes.push_back(8'h00);
          frame_bytes.push_back(8'h01);
          tb = 8'($urandom);
          r = $urandom_range(99);
          if (r < 5) tb[4:0] = TypeInvalid;
          else if (r < 20) tb[4:0] = TypeAud;
          frame_bytes.push_back(tb);
          plen = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 6);
          repeat (plen) begin
            pb = 8'($urandom);
            if ($urandom_range(6) == 0) pb = 8'h00;
            frame_bytes.push_back(pb);
          end
        end
        // broken buffer: cut anywhere, often inside a start code
        if (shape < 22) begin
          plen = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > plen) void'(frame_bytes.pop_back());
        end
      end
      send_buffer();
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    int      g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_units.size() == 0) begin
        flag_mismatch($sformatf("unexpected result v%0d t%0d off%0d len%0d", verdict_o,
                                unit_type_o, unit_offset_o, unit_length_o));
      end else begin
        want = want_units.pop_front();
        checked++;
        if (verdict_o !== want.verdict || unit_type_o !== want.unit_type ||
            unit_offset_o !== want.unit_offset || unit_length_o !== want.unit_length ||
            runs_to_end_o !== want.runs_to_end || end_of_run_o !== want.end_of_run) begin
          flag_mismatch($sformatf(
            "got v%0d t%0d off%0d len%0d end%0d last%0d, want v%0d t%0d off%0d len%0d end%0d last%0d",
            verdict_o, unit_type_o, unit_offset_o, unit_length_o, runs_to_end_o, end_of_run_o,
            want.verdict, want.unit_type, want.unit_offset, want.unit_length,
            want.runs_to_end, want.end_of_run));
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      g = stall_en ? pick_gap() : 0;
      if (g > 0) begin
        stall_left = g - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, want_units.size());
      $display("annexb_nal_unit_splitter_top_test: errors");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    data_byte_i  <= 8'h00;
    buffer_end_i <= 1'b0;
    reset_scan();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_buffers();
    in_valid_i <= 1'b0;
    while (want_units.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d buffers of %0d bytes in all, with random gaps on both sides",
             buffers, bytes_in);
    $display("%0d unit descriptors compared", checked);
    if (errors == 0) $display("annexb_nal_unit_splitter_top_test: clean");
    else $display("annexb_nal_unit_splitter_top_test: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/annexb_pkg.sv
rtl/annexb_nal_unit_splitter_top.sv
rtl/annexb_checker.sv
tb/annexb_nal_unit_splitter_top_test.sv
